// ===== rtl/suid_pkg.sv =====
// ----------------------------------------------------------------------------
// suid_pkg
// Shared types and constants for the set union / intersection / difference
// unit.
// ----------------------------------------------------------------------------
package suid_pkg;

	localparam int LIST_DEPTH = 16;
	localparam int MAX_OUT    = 32;
	localparam int DATA_W     = 32;
	localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
	localparam int RES_W      = $clog2(MAX_OUT + 1);

	typedef enum logic [1:0] {
		KIND_APPEND_A = 2'd0,
		KIND_APPEND_B = 2'd1,
		KIND_COMPUTE  = 2'd2,
		KIND_CLEAR    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OP_UNION     = 2'd0,
		OP_INTERSECT = 2'd1,
		OP_DIFF      = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_LOAD,
		S_SCAN,
		S_KEEP,
		S_FLUSH
	} state_t;

endpackage

// ===== rtl/suid_ifs.sv =====
// ----------------------------------------------------------------------------
// suid_ifs
// Valid/ready channels of the set unit: command beats in, result beats out.
// ----------------------------------------------------------------------------
interface suid_in_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          kind;
	logic signed [suid_pkg::DATA_W-1:0]  value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface

interface suid_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [suid_pkg::DATA_W-1:0]  element;
	logic                                last;
	logic                                empty_res;
	logic                                dropped;

	modport source (output valid, output element, output last, output empty_res,
		output dropped, input ready);
	modport sink   (input valid, input element, input last, input empty_res,
		input dropped, output ready);
endinterface

// ===== rtl/suid_ram.sv =====
// ----------------------------------------------------------------------------
// suid_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module suid_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/set_union_intersection_difference_unit.sv =====
// ----------------------------------------------------------------------------
// set_union_intersection_difference_unit
// Two bounded lists A and B held in RAM; a compute beat emits the union,
// intersection or difference selected by the operation register.
// ----------------------------------------------------------------------------
// Append and clear beats act as soon as they are taken. A compute beat walks
// the outer list one entry at a time and, for every outer entry, scans the
// other list one entry per cycle through that list's single RAM read port,
// stopping at the first match. Union is A first, then each B value absent
// from A; intersection is each B value present in A; difference is each A
// value absent from B. Results leave through an output register, so the
// next command beat is taken while the final result still waits. An empty
// result comes out as one beat with empty_res set. List RAMs need no
// clearing pass: only entries below each fill count are ever read.
// ----------------------------------------------------------------------------
module set_union_intersection_difference_unit (
	input  logic              clk,
	input  logic              arst_n,
	suid_in_if.sink           items,
	suid_out_if.source        results,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_wdata
);

	localparam int DW = suid_pkg::DATA_W;
	localparam int IW = suid_pkg::IDX_W;
	localparam int CW = suid_pkg::CNT_W;
	localparam int RW = suid_pkg::RES_W;

	suid_pkg::state_t state_q, state_d;

	logic [1:0]        operation_q;
	logic [CW-1:0]     count_a_q, count_b_q;
	logic              ovf_q;
	logic              copy_q, copy_d;
	logic              outer_b_q, outer_b_d;
	logic              want_q, want_d;
	logic [CW-1:0]     i_q, i_d;
	logic [CW-1:0]     j_q, j_d;
	logic              cmp_vld_s1, cmp_vld_d;
	logic [DW-1:0]     outer_q;
	logic [DW-1:0]     pend_q;
	logic              pend_vld_q, pend_vld_d;
	logic [RW-1:0]     res_cnt_q, res_cnt_d;

	logic              out_vld_q;
	logic [DW-1:0]     out_elem_q;
	logic              out_last_q, out_empty_q, out_drop_q;

	logic              in_fire, slot_free;
	logic              ld_outer, ld_pend, push, push_last, push_empty;
	logic              rd_outer, rd_inner, match;
	logic [CW-1:0]     outer_cnt, inner_cnt;

	logic              we_a, we_b, re_a, re_b;
	logic [IW-1:0]     raddr_a, raddr_b;
	logic [DW-1:0]     rdata_a, rdata_b, outer_rdata, inner_rdata;

	assign items.ready = (state_q == suid_pkg::S_IDLE);
	assign in_fire     = items.valid && items.ready;
	assign slot_free   = !out_vld_q || results.ready;

	assign outer_cnt   = outer_b_q ? count_b_q : count_a_q;
	assign inner_cnt   = outer_b_q ? count_a_q : count_b_q;
	assign outer_rdata = outer_b_q ? rdata_b : rdata_a;
	assign inner_rdata = outer_b_q ? rdata_a : rdata_b;

	assign we_a = in_fire && (items.kind == suid_pkg::KIND_APPEND_A)
		&& (count_a_q < CW'(suid_pkg::LIST_DEPTH));
	assign we_b = in_fire && (items.kind == suid_pkg::KIND_APPEND_B)
		&& (count_b_q < CW'(suid_pkg::LIST_DEPTH));

	assign re_a    = outer_b_q ? rd_inner : rd_outer;
	assign re_b    = outer_b_q ? rd_outer : rd_inner;
	assign raddr_a = outer_b_q ? j_q[IW-1:0] : i_q[IW-1:0];
	assign raddr_b = outer_b_q ? i_q[IW-1:0] : j_q[IW-1:0];

	suid_ram #(.WIDTH(DW), .DEPTH(suid_pkg::LIST_DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (count_a_q[IW-1:0]),
		.wdata (items.value),
		.re    (re_a),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	suid_ram #(.WIDTH(DW), .DEPTH(suid_pkg::LIST_DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (count_b_q[IW-1:0]),
		.wdata (items.value),
		.re    (re_b),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= suid_pkg::S_IDLE;
		end else begin
			state_q    <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		copy_d     = copy_q;
		outer_b_d  = outer_b_q;
		want_d     = want_q;
		i_d        = i_q;
		j_d        = j_q;
		cmp_vld_d  = 1'b0;
		pend_vld_d = pend_vld_q;
		res_cnt_d  = res_cnt_q;
		ld_outer   = 1'b0;
		ld_pend    = 1'b0;
		push       = 1'b0;
		push_last  = 1'b0;
		push_empty = 1'b0;
		rd_outer   = 1'b0;
		rd_inner   = 1'b0;
		match      = 1'b0;
		unique case (state_q)
			suid_pkg::S_IDLE: begin
				if (in_fire && (items.kind == suid_pkg::KIND_COMPUTE)) begin
					i_d        = '0;
					pend_vld_d = 1'b0;
					res_cnt_d  = '0;
					state_d    = suid_pkg::S_CHECK;
					case (operation_q)
						suid_pkg::OP_UNION: begin
							copy_d    = 1'b1;
							outer_b_d = 1'b0;
							want_d    = 1'b0;
						end
						suid_pkg::OP_INTERSECT: begin
							copy_d    = 1'b0;
							outer_b_d = 1'b1;
							want_d    = 1'b1;
						end
						suid_pkg::OP_DIFF: begin
							copy_d    = 1'b0;
							outer_b_d = 1'b0;
							want_d    = 1'b0;
						end
						default: begin
							state_d   = suid_pkg::S_FLUSH;
						end
					endcase
				end
			end
			suid_pkg::S_CHECK: begin
				if (i_q < outer_cnt) begin
					rd_outer = 1'b1;
					state_d  = suid_pkg::S_LOAD;
				end else if (copy_q) begin
					// advance to the B half of a union
					copy_d    = 1'b0;
					outer_b_d = 1'b1;
					want_d    = 1'b0;
					i_d       = '0;
				end else begin
					state_d   = suid_pkg::S_FLUSH;
				end
			end
			suid_pkg::S_LOAD: begin
				ld_outer = 1'b1;
				j_d      = '0;
				state_d  = copy_q ? suid_pkg::S_KEEP : suid_pkg::S_SCAN;
			end
			suid_pkg::S_SCAN: begin
				match = cmp_vld_s1 && (inner_rdata == outer_q);
				if (match) begin
					if (want_q) begin
						state_d = suid_pkg::S_KEEP;
					end else begin
						i_d     = i_q + CW'(1);
						state_d = suid_pkg::S_CHECK;
					end
				end else if (j_q < inner_cnt) begin
					rd_inner  = 1'b1;
					j_d       = j_q + CW'(1);
					cmp_vld_d = 1'b1;
				end else if (!cmp_vld_s1) begin
					if (want_q) begin
						i_d     = i_q + CW'(1);
						state_d = suid_pkg::S_CHECK;
					end else begin
						state_d = suid_pkg::S_KEEP;
					end
				end
			end
			suid_pkg::S_KEEP: begin
				if (!pend_vld_q || slot_free) begin
					push       = pend_vld_q;
					ld_pend    = 1'b1;
					pend_vld_d = 1'b1;
					res_cnt_d  = res_cnt_q + RW'(1);
					i_d        = i_q + CW'(1);
					if (res_cnt_q + RW'(1) == RW'(suid_pkg::MAX_OUT)) begin
						state_d = suid_pkg::S_FLUSH;
					end else begin
						state_d = suid_pkg::S_CHECK;
					end
				end
			end
			suid_pkg::S_FLUSH: begin
				if (slot_free) begin
					push       = 1'b1;
					push_last  = 1'b1;
					push_empty = !pend_vld_q;
					pend_vld_d = 1'b0;
					state_d    = suid_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = suid_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			operation_q <= '0;
			count_a_q   <= '0;
			count_b_q   <= '0;
			ovf_q       <= 1'b0;
			copy_q      <= 1'b0;
			outer_b_q   <= 1'b0;
			want_q      <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			cmp_vld_s1  <= 1'b0;
			pend_vld_q  <= 1'b0;
			res_cnt_q   <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				operation_q <= cfg_wdata;
			end
			if (in_fire) begin
				case (items.kind)
					suid_pkg::KIND_APPEND_A: begin
						if (we_a) begin
							count_a_q <= count_a_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					suid_pkg::KIND_APPEND_B: begin
						if (we_b) begin
							count_b_q <= count_b_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					suid_pkg::KIND_CLEAR: begin
						count_a_q <= '0;
						count_b_q <= '0;
						ovf_q     <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			copy_q     <= copy_d;
			outer_b_q  <= outer_b_d;
			want_q     <= want_d;
			i_q        <= i_d;
			j_q        <= j_d;
			cmp_vld_s1 <= cmp_vld_d;
			pend_vld_q <= pend_vld_d;
			res_cnt_q  <= res_cnt_d;
			if (push) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_outer) begin
			outer_q <= outer_rdata;
		end
		if (ld_pend) begin
			pend_q <= outer_q;
		end
		if (push) begin
			out_elem_q  <= push_empty ? '0 : pend_q;
			out_last_q  <= push_last;
			out_empty_q <= push_empty;
			out_drop_q  <= ovf_q;
		end
	end

	assign results.valid     = out_vld_q;
	assign results.element   = out_elem_q;
	assign results.last      = out_last_q;
	assign results.empty_res = out_empty_q;
	assign results.dropped   = out_drop_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the set union / intersection / difference unit.
// Command beats are sent from a queue; an in-bench copy of both lists
// predicts each result beat, and every beat leaving the unit is compared
// against the oldest prediction. Runs each operation, including the unused
// code, under several backpressure patterns.
// ----------------------------------------------------------------------------
module tb;
	import suid_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		kind_t              kind;
		logic signed [31:0] value;
		bit                 hold;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] element;
		logic               last;
		logic               empty_res;
		logic               dropped;
	} set_beat_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_wdata;

	suid_in_if  in_ch ();
	suid_out_if out_ch ();

	set_union_intersection_difference_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (in_ch),
		.results   (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	cmd_t               cmd_q [$];
	cmd_t               drv_cmd;
	set_beat_t          expected_results [$];
	set_beat_t          got;
	set_beat_t          exp_beat;
	int                 tx_idle_pct = 0;
	int                 rx_idle_pct = 0;
	bit                 results_drained = 1'b1;
	int                 bad_beats = 0;

	logic signed [31:0] model_a [LIST_DEPTH];
	logic signed [31:0] model_b [LIST_DEPTH];
	int                 model_cnt_a;
	int                 model_cnt_b;
	logic               model_dropped;
	logic [1:0]         model_op;
	int                 run_len;

	logic [1:0] op_plan [7] = '{OP_UNION, OP_INTERSECT, OP_DIFF, OP_UNUSED,
		OP_UNION, OP_DIFF, OP_INTERSECT};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit found_in(input logic signed [31:0] lst [LIST_DEPTH],
			input int n, input logic signed [31:0] v);
		for (int i = 0; i < n; i++) begin
			if (lst[i] == v) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void add_result(input logic signed [31:0] v);
		if (run_len < MAX_OUT) begin
			expected_results.push_back('{element: v, last: 1'b0, empty_res: 1'b0,
				dropped: model_dropped});
		end
		run_len++;
	endfunction

	function automatic void predict_command(input kind_t k, input logic signed [31:0] v);
		run_len = 0;
		case (k)
		KIND_APPEND_A: begin
			if (model_cnt_a < LIST_DEPTH) begin
				model_a[model_cnt_a] = v;
				model_cnt_a++;
			end else begin
				model_dropped = 1'b1;
			end
		end
		KIND_APPEND_B: begin
			if (model_cnt_b < LIST_DEPTH) begin
				model_b[model_cnt_b] = v;
				model_cnt_b++;
			end else begin
				model_dropped = 1'b1;
			end
		end
		KIND_CLEAR: begin
			model_cnt_a = 0;
			model_cnt_b = 0;
			model_dropped = 1'b0;
		end
		default: begin
			case (model_op)
			OP_UNION: begin
				for (int i = 0; i < model_cnt_a; i++) begin
					add_result(model_a[i]);
				end
				for (int i = 0; i < model_cnt_b; i++) begin
					if (!found_in(model_a, model_cnt_a, model_b[i])) begin
						add_result(model_b[i]);
					end
				end
			end
			OP_INTERSECT: begin
				for (int i = 0; i < model_cnt_b; i++) begin
					if (found_in(model_a, model_cnt_a, model_b[i])) begin
						add_result(model_b[i]);
					end
				end
			end
			OP_DIFF: begin
				for (int i = 0; i < model_cnt_a; i++) begin
					if (!found_in(model_b, model_cnt_b, model_a[i])) begin
						add_result(model_a[i]);
					end
				end
			end
			default: begin
			end
			endcase
			if (run_len == 0) begin
				expected_results.push_back('{element: 32'sd0, last: 1'b1, empty_res: 1'b1,
					dropped: model_dropped});
			end else begin
				expected_results[expected_results.size() - 1].last = 1'b1;
			end
		end
		endcase
	endfunction

	function automatic void add_cmd(input kind_t k, input logic signed [31:0] v,
			input bit hold);
		cmd_q.push_back('{kind: k, value: v, hold: hold});
	endfunction

	function automatic logic signed [31:0] pick_value();
		if ($urandom_range(9) < 7) begin
			return int'($urandom_range(8)) - 4;
		end
		return $urandom;
	endfunction

	task automatic queue_random(input int target);
		int                 added;
		int                 na;
		int                 nb;
		logic signed [31:0] v;
		logic signed [31:0] pool [$];
		added = 0;
		while (added < target) begin
			if ($urandom_range(99) < 12) begin
				add_cmd(kind_t'($urandom_range(3)), $urandom, 1'b0);
				added++;
			end else begin
				pool.delete();
				if ($urandom_range(3) != 0) begin
					add_cmd(KIND_CLEAR, $urandom, $urandom_range(9) == 0);
					added++;
				end
				na = ($urandom_range(9) == 0) ? $urandom_range(14, 18) : $urandom_range(6);
				nb = ($urandom_range(9) == 0) ? $urandom_range(14, 18) : $urandom_range(6);
				for (int i = 0; i < na; i++) begin
					v = pick_value();
					pool.push_back(v);
					add_cmd(KIND_APPEND_A, v, 1'b0);
				end
				for (int i = 0; i < nb; i++) begin
					if (pool.size() != 0 && $urandom_range(1) == 1) begin
						v = pool[$urandom_range(pool.size() - 1)];
					end else begin
						v = pick_value();
					end
					add_cmd(KIND_APPEND_B, v, 1'b0);
				end
				add_cmd(KIND_COMPUTE, $urandom, 1'b0);
				added += na + nb + 1;
				if ($urandom_range(3) == 0) begin
					add_cmd(KIND_COMPUTE, $urandom, 1'b0);
					added++;
				end
			end
		end
	endtask

	// command driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (cmd_q.size() != 0 && $urandom_range(99) >= tx_idle_pct
					&& !(cmd_q[0].hold && (in_ch.valid || !results_drained))) begin
				drv_cmd = cmd_q.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.kind  <= drv_cmd.kind;
				in_ch.value <= drv_cmd.value;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// monitor: predict on accepted commands, check accepted results
	always @(posedge clk) begin
		if (!arst_n) begin
			model_cnt_a = 0;
			model_cnt_b = 0;
			model_dropped = 1'b0;
			model_op = OP_UNION;
			results_drained <= 1'b1;
		end else begin
			if (cfg_we) begin
				model_op = cfg_wdata;
			end
			if (in_ch.valid && in_ch.ready) begin
				predict_command(kind_t'(in_ch.kind), in_ch.value);
			end
			if (out_ch.valid && out_ch.ready) begin
				got = '{element: out_ch.element, last: out_ch.last,
					empty_res: out_ch.empty_res, dropped: out_ch.dropped};
				if (expected_results.size() == 0) begin
					if (bad_beats < 10) begin
						$display("unexpected beat: element %0d last %0b empty %0b dropped %0b",
							got.element, got.last, got.empty_res, got.dropped);
					end
					bad_beats++;
				end else begin
					exp_beat = expected_results.pop_front();
					if (got.element !== exp_beat.element || got.last !== exp_beat.last
							|| got.empty_res !== exp_beat.empty_res
							|| got.dropped !== exp_beat.dropped) begin
						if (bad_beats < 10) begin
							$display("mismatch: expected element %0d last %0b empty %0b dropped %0b",
								exp_beat.element, exp_beat.last, exp_beat.empty_res,
								exp_beat.dropped);
							$display("          got element %0d last %0b empty %0b dropped %0b",
								got.element, got.last, got.empty_res, got.dropped);
						end
						bad_beats++;
					end
				end
			end
			results_drained <= (expected_results.size() == 0);
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 2'd0;
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_APPEND_A;
		in_ch.value = 32'sd0;
		out_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < 7; p++) begin
			tx_idle_pct = (p < 3) ? 35 : ((p < 5) ? 63 : 0);
			rx_idle_pct = (p < 3) ? 63 : ((p < 5) ? 35 : 0);
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_wdata <= op_plan[p];
			@(posedge clk);
			cfg_we <= 1'b0;
			if (p == 0) begin
				// compute on empty lists, extremes, matches, overflow of B
				add_cmd(KIND_COMPUTE, 32'h1234_5678, 1'b0);
				add_cmd(KIND_APPEND_A, 32'h7FFF_FFFF, 1'b0);
				add_cmd(KIND_APPEND_A, 32'h8000_0000, 1'b0);
				add_cmd(KIND_APPEND_A, -32'sd1, 1'b0);
				add_cmd(KIND_APPEND_B, -32'sd1, 1'b0);
				add_cmd(KIND_APPEND_B, 32'sd1, 1'b0);
				add_cmd(KIND_APPEND_B, 32'h8000_0000, 1'b0);
				add_cmd(KIND_COMPUTE, 32'hFFFF_FFFF, 1'b0);
				add_cmd(KIND_CLEAR, 32'hA5A5_5A5A, 1'b1);
				add_cmd(KIND_COMPUTE, 32'sd0, 1'b0);
				for (int i = 0; i <= LIST_DEPTH; i++) begin
					add_cmd(KIND_APPEND_B, i, 1'b0);
				end
				add_cmd(KIND_COMPUTE, 32'sd0, 1'b0);
			end
			queue_random((p == 0) ? 20 : 36);
			do begin
				@(negedge clk);
			end while (cmd_q.size() != 0 || in_ch.valid || expected_results.size() != 0);
			repeat (20) @(negedge clk);
		end
		if (bad_beats == 0 && expected_results.size() == 0) begin
			$display("PASS set_union_intersection_difference_unit");
		end else begin
			$display("FAIL set_union_intersection_difference_unit");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("FAIL set_union_intersection_difference_unit");
		$finish;
	end

endmodule
